### design/mpfb_pkg.sv
// shared types and constants for the max pooling block
// no dependencies
`default_nettype none

package mpfb_pkg;

    // width of internal geometry arithmetic (dimensions, origins, sums)
    localparam int GW = 10;

    // configuration register indexes
    localparam logic [2:0] REG_IN_HEIGHT   = 3'd0;
    localparam logic [2:0] REG_IN_WIDTH    = 3'd1;
    localparam logic [2:0] REG_IN_CHANNELS = 3'd2;
    localparam logic [2:0] REG_WIN_HEIGHT  = 3'd3;
    localparam logic [2:0] REG_WIN_WIDTH   = 3'd4;
    localparam logic [2:0] REG_V_STRIDE    = 3'd5;
    localparam logic [2:0] REG_H_STRIDE    = 3'd6;

    // item kinds
    localparam logic [1:0] KIND_IMAGE  = 2'd0;
    localparam logic [1:0] KIND_GRAD   = 2'd1;
    localparam logic [1:0] KIND_READ   = 2'd2;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    // commands from controller to datapath
    typedef struct packed {
        logic accept;
        logic img_write;
        logic scan_init;
        logic scan_step;
        logic clr_step;
        logic grd_rd;
        logic grd_wr;
        logic rd_issue;
        logic load_out;
    } mpfb_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic       pos_zero;
        logic       corner;
        logic       grad_ok;
        logic       scan_last;
        logic       clr_done;
        logic       out_free;
        logic [1:0] held_kind;
    } mpfb_stat_t;

endpackage

`default_nettype wire

### design/mpfb_ctrl.sv
// controller state machine for the max pooling block
// depends on mpfb_pkg
`default_nettype none

module mpfb_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic [1:0]         in_kind,
    output logic                    in_ready,
    input  wire mpfb_pkg::mpfb_stat_t stat,
    output mpfb_pkg::mpfb_cmd_t     cmd
);
    import mpfb_pkg::*;

    typedef enum logic [8:0] {
        S_CLEAR  = 9'b000000001,
        S_IDLE   = 9'b000000010,
        S_IMG    = 9'b000000100,
        S_SCAN   = 9'b000001000,
        S_DRAIN  = 9'b000010000,
        S_GRD_RD = 9'b000100000,
        S_GRD_WR = 9'b001000000,
        S_RD     = 9'b010000000,
        S_OUT    = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    logic   pend_reg, pend_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        pend_next  = pend_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_done)
                begin
                    pend_next  = 1'b0;
                    state_next = pend_reg ? S_IMG : S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept    = 1'b1;
                    cmd.scan_init = 1'b1;
                    case (in_kind)
                        KIND_IMAGE:
                        begin
                            if (stat.pos_zero)
                            begin
                                pend_next  = 1'b1;
                                state_next = S_CLEAR;
                            end
                            else
                            begin
                                state_next = S_IMG;
                            end
                        end
                        KIND_GRAD: state_next = stat.grad_ok ? S_SCAN : S_IDLE;
                        KIND_READ: state_next = S_RD;
                        default:   state_next = S_IDLE;
                    endcase
                end
            end
            S_IMG:
            begin
                cmd.img_write = 1'b1;
                cmd.scan_init = 1'b1;
                state_next    = stat.corner ? S_SCAN : S_IDLE;
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_last)
                    state_next = S_DRAIN;
            end
            S_DRAIN:
                state_next = (stat.held_kind == KIND_IMAGE) ? S_OUT : S_GRD_RD;
            S_GRD_RD:
            begin
                cmd.grd_rd = 1'b1;
                state_next = S_GRD_WR;
            end
            S_GRD_WR:
            begin
                cmd.grd_wr = 1'b1;
                state_next = S_IDLE;
            end
            S_RD:
            begin
                cmd.rd_issue = 1'b1;
                state_next   = S_OUT;
            end
            S_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

`default_nettype wire

### design/mpfb_dp.sv
// datapath for the max pooling block: registers, counters, stores, output stage
// depends on mpfb_pkg
`default_nettype none

module mpfb_dp #(
    parameter int MAX_HEIGHT   = 32,
    parameter int MAX_WIDTH    = 32,
    parameter int MAX_CHANNELS = 8,
    parameter int VALUE_BITS   = 16
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire mpfb_pkg::mpfb_cmd_t     cmd,
    output mpfb_pkg::mpfb_stat_t         stat,
    input  wire logic [1:0]              kind,
    input  wire logic [VALUE_BITS-1:0]   value,
    input  wire logic [2:0]              read_channel,
    input  wire logic [4:0]              read_row,
    input  wire logic [4:0]              read_col,
    input  wire logic                    cfg_valid,
    input  wire logic [2:0]              cfg_index,
    input  wire logic [5:0]              cfg_data,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic                         result_kind,
    output logic [VALUE_BITS-1:0]        result_value,
    output logic [2:0]                   out_channel,
    output logic [4:0]                   out_row,
    output logic [4:0]                   out_col
);
    import mpfb_pkg::*;

    localparam int CW    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int RW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int WW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int AW    = CW + RW + WW;
    localparam int DEPTH = 1 << AW;
    localparam logic [GW-1:0] MH   = GW'(MAX_HEIGHT);
    localparam logic [GW-1:0] MW   = GW'(MAX_WIDTH);
    localparam logic [GW-1:0] MC   = GW'(MAX_CHANNELS);
    localparam logic [GW-1:0] MS   = GW'(63);
    localparam logic [GW-1:0] ONE  = GW'(1);
    localparam logic [VALUE_BITS-1:0] VMAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
    localparam logic [VALUE_BITS-1:0] VMIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

    function automatic logic [GW-1:0] clampd(input logic [5:0] v, input logic [GW-1:0] hi);
        logic [GW-1:0] x;
        x = GW'(v);
        if (x == '0)
            clampd = ONE;
        else if (x > hi)
            clampd = hi;
        else
            clampd = x;
    endfunction

    // configuration registers, only defined indexes take effect
    logic [5:0] h_cfg_reg, w_cfg_reg, c_cfg_reg, wh_cfg_reg, ww_cfg_reg, vs_cfg_reg, hs_cfg_reg;
    logic       cfg_we;
    assign cfg_we = cfg_valid && (cfg_index <= REG_H_STRIDE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h_cfg_reg  <= 6'd28;
            w_cfg_reg  <= 6'd28;
            c_cfg_reg  <= 6'd6;
            wh_cfg_reg <= 6'd2;
            ww_cfg_reg <= 6'd2;
            vs_cfg_reg <= 6'd2;
            hs_cfg_reg <= 6'd2;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_IN_HEIGHT:   h_cfg_reg  <= cfg_data;
                REG_IN_WIDTH:    w_cfg_reg  <= cfg_data;
                REG_IN_CHANNELS: c_cfg_reg  <= {2'b00, cfg_data[3:0]};
                REG_WIN_HEIGHT:  wh_cfg_reg <= cfg_data;
                REG_WIN_WIDTH:   ww_cfg_reg <= cfg_data;
                REG_V_STRIDE:    vs_cfg_reg <= cfg_data;
                REG_H_STRIDE:    hs_cfg_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    // clamped geometry
    logic [GW-1:0] g_h, g_w, g_c, g_wh, g_ww, g_vs, g_hs;
    assign g_h  = clampd(h_cfg_reg, MH);
    assign g_w  = clampd(w_cfg_reg, MW);
    assign g_c  = clampd(c_cfg_reg, MC);
    assign g_wh = clampd(wh_cfg_reg, MH);
    assign g_ww = clampd(ww_cfg_reg, MW);
    assign g_vs = clampd(vs_cfg_reg, MS);
    assign g_hs = clampd(hs_cfg_reg, MS);

    // held input item
    logic [1:0]            k_reg;
    logic [VALUE_BITS-1:0] v_reg;
    logic [2:0]            rch_reg;
    logic [4:0]            rr_reg, rc_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            k_reg   <= kind;
            v_reg   <= value;
            rch_reg <= read_channel;
            rr_reg  <= read_row;
            rc_reg  <= read_col;
        end
    end

    // image position and window corner trackers
    logic [GW-1:0] ich_reg, ir_reg, icol_reg, roff_reg, coff_reg, prow_reg, pcol_reg;
    logic          col_end, row_end, ch_end, row_hit, col_hit;
    assign col_hit = (icol_reg + ONE) == (coff_reg + g_ww);
    assign row_hit = (ir_reg + ONE) == (roff_reg + g_wh);
    assign col_end = (icol_reg + ONE) == g_w;
    assign row_end = (ir_reg + ONE) == g_h;
    assign ch_end  = (ich_reg + ONE) == g_c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ich_reg  <= '0;
            ir_reg   <= '0;
            icol_reg <= '0;
            roff_reg <= '0;
            coff_reg <= '0;
            prow_reg <= '0;
            pcol_reg <= '0;
        end
        else if (cfg_we)
        begin
            ich_reg  <= '0;
            ir_reg   <= '0;
            icol_reg <= '0;
            roff_reg <= '0;
            coff_reg <= '0;
            prow_reg <= '0;
            pcol_reg <= '0;
        end
        else if (cmd.img_write)
        begin
            if (col_end)
            begin
                icol_reg <= '0;
                coff_reg <= '0;
                pcol_reg <= '0;
                if (row_end)
                begin
                    ir_reg   <= '0;
                    roff_reg <= '0;
                    prow_reg <= '0;
                    ich_reg  <= ch_end ? '0 : ich_reg + ONE;
                end
                else
                begin
                    ir_reg <= ir_reg + ONE;
                    if (row_hit)
                    begin
                        roff_reg <= roff_reg + g_vs;
                        prow_reg <= prow_reg + ONE;
                    end
                end
            end
            else
            begin
                icol_reg <= icol_reg + ONE;
                if (col_hit)
                begin
                    coff_reg <= coff_reg + g_hs;
                    pcol_reg <= pcol_reg + ONE;
                end
            end
        end
    end

    // gradient position
    logic [GW-1:0] gch_reg, gr0_reg, gc0_reg;
    logic          grad_ok, grad_go;
    assign grad_ok = (g_wh <= g_h) && (g_ww <= g_w);
    assign grad_go = cmd.accept && (kind == KIND_GRAD) && grad_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gch_reg <= '0;
            gr0_reg <= '0;
            gc0_reg <= '0;
        end
        else if (cfg_we || cmd.clr_step)
        begin
            gch_reg <= '0;
            gr0_reg <= '0;
            gc0_reg <= '0;
        end
        else if (grad_go)
        begin
            if (gc0_reg + g_hs + g_ww <= g_w)
            begin
                gc0_reg <= gc0_reg + g_hs;
            end
            else
            begin
                gc0_reg <= '0;
                if (gr0_reg + g_vs + g_wh <= g_h)
                begin
                    gr0_reg <= gr0_reg + g_vs;
                end
                else
                begin
                    gr0_reg <= '0;
                    gch_reg <= ((gch_reg + ONE) == g_c) ? '0 : gch_reg + ONE;
                end
            end
        end
    end

    // window origin and pooled index for the scan
    logic [GW-1:0] wch_reg, wr0_reg, wc0_reg, wpr_reg, wpc_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.img_write)
        begin
            wch_reg <= ich_reg;
            wr0_reg <= roff_reg;
            wc0_reg <= coff_reg;
            wpr_reg <= prow_reg;
            wpc_reg <= pcol_reg;
        end
        else if (grad_go)
        begin
            wch_reg <= gch_reg;
            wr0_reg <= gr0_reg;
            wc0_reg <= gc0_reg;
        end
    end

    // window scan counters, column-major
    logic [GW-1:0] si_reg, sj_reg;
    logic          scan_last;
    assign scan_last = (si_reg + ONE == g_wh) && (sj_reg + ONE == g_ww);

    always_ff @(posedge clk)
    begin
        if (cmd.scan_init)
        begin
            si_reg <= '0;
            sj_reg <= '0;
        end
        else if (cmd.scan_step)
        begin
            if (si_reg + ONE == g_wh)
            begin
                si_reg <= '0;
                sj_reg <= sj_reg + ONE;
            end
            else
            begin
                si_reg <= si_reg + ONE;
            end
        end
    end

    // image store
    logic [VALUE_BITS-1:0] img_mem [DEPTH];
    logic [VALUE_BITS-1:0] img_rdata_reg;
    logic [AW-1:0]         img_waddr, img_raddr;
    logic [GW-1:0]         scan_r, scan_c;
    assign scan_r    = wr0_reg + si_reg;
    assign scan_c    = wc0_reg + sj_reg;
    assign img_waddr = {ich_reg[CW-1:0], ir_reg[RW-1:0], icol_reg[WW-1:0]};
    assign img_raddr = {wch_reg[CW-1:0], scan_r[RW-1:0], scan_c[WW-1:0]};

    always_ff @(posedge clk)
    begin
        if (cmd.img_write)
            img_mem[img_waddr] <= v_reg;
        if (cmd.scan_step)
            img_rdata_reg <= img_mem[img_raddr];
    end

    // running maximum over the scanned window
    logic                  cmp_v_reg, first_reg;
    logic [GW-1:0]         di_reg, dj_reg, bi_reg, bj_reg;
    logic [VALUE_BITS-1:0] best_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmp_v_reg <= 1'b0;
            first_reg <= 1'b0;
        end
        else
        begin
            cmp_v_reg <= cmd.scan_step;
            if (cmd.scan_init)
                first_reg <= 1'b1;
            else if (cmp_v_reg)
                first_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        di_reg <= si_reg;
        dj_reg <= sj_reg;
        if (cmp_v_reg && (first_reg || ($signed(img_rdata_reg) > $signed(best_reg))))
        begin
            best_reg <= img_rdata_reg;
            bi_reg   <= di_reg;
            bj_reg   <= dj_reg;
        end
    end

    // gradient store, cleared by a sweep
    logic [VALUE_BITS-1:0] grd_mem [DEPTH];
    logic [VALUE_BITS-1:0] grd_rdata_reg;
    logic [AW:0]           clr_cnt_reg;
    logic [AW-1:0]         best_addr, rd_addr, grd_raddr;
    logic [GW-1:0]         best_r, best_c, rd_ch, rd_r, rd_c;
    logic                  rd_ok, rd_ok_reg;
    logic [VALUE_BITS:0]   sum;
    logic [VALUE_BITS-1:0] sat;

    assign best_r    = wr0_reg + bi_reg;
    assign best_c    = wc0_reg + bj_reg;
    assign best_addr = {wch_reg[CW-1:0], best_r[RW-1:0], best_c[WW-1:0]};
    assign rd_ch     = GW'(rch_reg);
    assign rd_r      = GW'(rr_reg);
    assign rd_c      = GW'(rc_reg);
    assign rd_ok     = (rd_ch < g_c) && (rd_r < g_h) && (rd_c < g_w);
    assign rd_addr   = {rd_ch[CW-1:0], rd_r[RW-1:0], rd_c[WW-1:0]};
    assign grd_raddr = cmd.rd_issue ? rd_addr : best_addr;

    // saturating add of the held gradient
    assign sum = {grd_rdata_reg[VALUE_BITS-1], grd_rdata_reg} + {v_reg[VALUE_BITS-1], v_reg};
    always_comb
    begin
        if (sum[VALUE_BITS] != sum[VALUE_BITS-1])
            sat = sum[VALUE_BITS] ? VMIN : VMAX;
        else
            sat = sum[VALUE_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_cnt_reg <= '0;
        else if (cmd.clr_step)
            clr_cnt_reg <= stat.clr_done ? '0 : clr_cnt_reg + 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clr_step)
            grd_mem[clr_cnt_reg[AW-1:0]] <= '0;
        else if (cmd.grd_wr)
            grd_mem[best_addr] <= sat;
        if (cmd.grd_rd || cmd.rd_issue)
            grd_rdata_reg <= grd_mem[grd_raddr];
        if (cmd.rd_issue)
            rd_ok_reg <= rd_ok;
    end

    // output stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid <= 1'b0;
        else if (cmd.load_out)
            out_valid <= 1'b1;
        else if (out_ready)
            out_valid <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            if (k_reg == KIND_IMAGE)
            begin
                result_kind  <= 1'b0;
                result_value <= best_reg;
                out_channel  <= wch_reg[2:0];
                out_row      <= wpr_reg[4:0];
                out_col      <= wpc_reg[4:0];
            end
            else
            begin
                result_kind  <= 1'b1;
                result_value <= rd_ok_reg ? grd_rdata_reg : '0;
                out_channel  <= rch_reg;
                out_row      <= rr_reg;
                out_col      <= rc_reg;
            end
        end
    end

    // status
    assign stat.pos_zero  = (ich_reg == '0) && (ir_reg == '0) && (icol_reg == '0);
    assign stat.corner    = row_hit && col_hit;
    assign stat.grad_ok   = grad_ok;
    assign stat.scan_last = scan_last;
    assign stat.clr_done  = (clr_cnt_reg == (AW+1)'(DEPTH - 1));
    assign stat.out_free  = !out_valid || out_ready;
    assign stat.held_kind = k_reg;

endmodule

`default_nettype wire

### design/max_pool_forward_backward.sv
// top level of the max pooling block with argmax gradient routing
// depends on mpfb_pkg, mpfb_ctrl, mpfb_dp
`default_nettype none

// Max pooling with argmax gradient routing, signed fixed point. Items are taken
// one at a time. An image element that completes no window is only written to
// the image store; one that completes a window is also followed by a window
// scan and the output load, since one image-store read port scans the window
// one entry per cycle. A gradient element takes a window scan, then a read and
// a write of the gradient store. A read takes a gradient-store read and the
// output load. After reset, and when the first element of a new image arrives,
// the gradient store is cleared by a sweep over all 2**(clog2 channels +
// clog2 rows + clog2 cols) entries (8192 at the default sizes) during which no
// item is taken. Configuration writes are taken at any time; a write to a
// defined register restarts both position counters, other indexes are ignored.
module max_pool_forward_backward #(
    parameter int MAX_HEIGHT   = 32,
    parameter int MAX_WIDTH    = 32,
    parameter int MAX_CHANNELS = 8,
    parameter int VALUE_BITS   = 16
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [1:0]            kind,
    input  wire logic [VALUE_BITS-1:0] value,
    input  wire logic [2:0]            read_channel,
    input  wire logic [4:0]            read_row,
    input  wire logic [4:0]            read_col,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic                       result_kind,
    output logic [VALUE_BITS-1:0]      result_value,
    output logic [2:0]                 out_channel,
    output logic [4:0]                 out_row,
    output logic [4:0]                 out_col,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [2:0]            cfg_index,
    input  wire logic [5:0]            cfg_data
);
    import mpfb_pkg::*;

    mpfb_cmd_t  cmd;
    mpfb_stat_t stat;

    assign cfg_ready = 1'b1;

    // sequencer
    mpfb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_kind  (kind),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // stores, counters and output stage
    mpfb_dp #(
        .MAX_HEIGHT   (MAX_HEIGHT),
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_CHANNELS (MAX_CHANNELS),
        .VALUE_BITS   (VALUE_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .kind         (kind),
        .value        (value),
        .read_channel (read_channel),
        .read_row     (read_row),
        .read_col     (read_col),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .result_kind  (result_kind),
        .result_value (result_value),
        .out_channel  (out_channel),
        .out_row      (out_row),
        .out_col      (out_col)
    );

endmodule

`default_nettype wire
